// ----- hw/rtl/wrr_pkg.sv -----
// Shared types, constants and fixed-point helpers for the reprojection residual unit.
`timescale 1ns / 1ps
package wrr_pkg;

  localparam int FOCAL_GAIN_DEF = 460;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 192;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [31:0] q_t;
  typedef logic signed [47:0] p_t;
  typedef p_t qp9_t [9];
  typedef q_t mat_t [3][3];

  localparam q_t Q_ONE     = 32'sd65536;
  localparam q_t Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN     = 32'sh8000_0000;
  localparam q_t DEPTH_EPS = 32'sd66;

  localparam logic [1:0] OP_POS   = 2'd0;
  localparam logic [1:0] OP_ROT   = 2'd1;
  localparam logic [1:0] OP_POINT = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_QZ   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_JSEL = 3'd7;

  localparam int JSEL_POSE = 0;
  localparam int JSEL_EXT  = 1;

  typedef enum logic [2:0] {
    ROW_RES    = 3'd0,
    ROW_POSE_U = 3'd1,
    ROW_POSE_V = 3'd2,
    ROW_EXT_U  = 3'd3,
    ROW_EXT_V  = 3'd4
  } row_kind_t;

  // pipeline stage map
  localparam int S_SUB      = 1;
  localparam int S_RMAT     = 2;
  localparam int S_BPRD     = 3;
  localparam int S_BSUM     = 4;
  localparam int S_OFS      = 5;
  localparam int S_CPRD     = 6;
  localparam int S_CSUM     = 7;
  localparam int S_DINIT    = 8;
  localparam int S_JPRD     = 9;
  localparam int S_JSUM     = 10;
  localparam int QUO_W      = 48;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int S_DIV0     = 9;
  localparam int S_QUOT     = S_DIV0 + DIV_STAGES;
  localparam int S_ERR      = S_QUOT + 1;
  localparam int S_WRES     = S_QUOT + 2;
  localparam int S_RSAT     = S_QUOT + 3;
  localparam int S_RED      = S_QUOT + 4;
  localparam int S_CRP      = S_QUOT + 5;
  localparam int S_CR       = S_QUOT + 6;
  localparam int S_EPRD     = S_QUOT + 7;
  localparam int S_ROW      = S_QUOT + 8;
  localparam int NSTG       = S_ROW + 1;

  typedef struct {
    logic             vld;
    logic [1:0]       op;
    q_t               v [4];
    q_t               ou;
    q_t               ov;
    q_t               conf;
    p_t               qp [9];
    p_t               wp;
    q_t               w;
    q_t               d [3];
    q_t               rb [3][3];
    p_t               p [3][3];
    q_t               imu [3];
    q_t               e [3];
    q_t               cam [3];
    q_t               dep;
    logic [31:0]      dmag;
    logic             dneg;
    logic [31:0]      rem [3];
    logic [QUO_W-1:0] quo [3];
    logic             an [3];
    logic             az [3];
    q_t               nrb [3][3];
    q_t               sku [3][3];
    q_t               skc [3][3];
    p_t               jp [3][3][3][3];
    q_t               jm [3][3][3];
    q_t               qt [3];
    q_t               rx;
    q_t               ry;
    p_t               mxi;
    p_t               myi;
    p_t               ig;
    p_t               resu_p;
    p_t               resv_p;
    q_t               red0;
    q_t               tx;
    q_t               ty;
    q_t               resu;
    q_t               resv;
    p_t               redx_p;
    p_t               redy_p;
    q_t               redx;
    q_t               redy;
    p_t               crp [3];
    q_t               cr [2][3];
    p_t               ep [2][2][6][3];
    q_t               jr [2][2][6];
  } item_t;

  typedef struct {
    q_t pos [3];
    q_t et [3];
    q_t rb [3][3];
    q_t rc [3][3];
    q_t nrc [3][3];
  } ctx_t;

  function automatic q_t sat32(input logic signed [63:0] a);
    priority if (a > 64'sd2147483647) begin
      return Q_MAX;
    end else if (a < -64'sd2147483648) begin
      return Q_MIN;
    end else begin
      return a[31:0];
    end
  endfunction

  function automatic p_t mulq(input q_t a, input q_t b);
    logic signed [63:0] t;
    t = 64'(a) * 64'(b);
    return t[63:16];
  endfunction

  // products xx yy zz xy xz yz xw yw zw
  function automatic qp9_t quat_prod(input q_t x, input q_t y, input q_t z, input q_t w);
    qp9_t r;
    r[0] = mulq(x, x);
    r[1] = mulq(y, y);
    r[2] = mulq(z, z);
    r[3] = mulq(x, y);
    r[4] = mulq(x, z);
    r[5] = mulq(y, z);
    r[6] = mulq(x, w);
    r[7] = mulq(y, w);
    r[8] = mulq(z, w);
    return r;
  endfunction

  function automatic mat_t quat_mat(input qp9_t q);
    mat_t m;
    m[0][0] = sat32(64'sd65536 - 2 * (64'(q[1]) + 64'(q[2])));
    m[0][1] = sat32(2 * (64'(q[3]) - 64'(q[8])));
    m[0][2] = sat32(2 * (64'(q[4]) + 64'(q[7])));
    m[1][0] = sat32(2 * (64'(q[3]) + 64'(q[8])));
    m[1][1] = sat32(64'sd65536 - 2 * (64'(q[0]) + 64'(q[2])));
    m[1][2] = sat32(2 * (64'(q[5]) - 64'(q[6])));
    m[2][0] = sat32(2 * (64'(q[4]) - 64'(q[7])));
    m[2][1] = sat32(2 * (64'(q[5]) + 64'(q[6])));
    m[2][2] = sat32(64'sd65536 - 2 * (64'(q[0]) + 64'(q[1])));
    return m;
  endfunction

  function automatic mat_t skew(input q_t v0, input q_t v1, input q_t v2);
    mat_t s;
    s[0][0] = '0;
    s[0][1] = sat32(-64'(v2));
    s[0][2] = v1;
    s[1][0] = v2;
    s[1][1] = '0;
    s[1][2] = sat32(-64'(v0));
    s[2][0] = sat32(-64'(v1));
    s[2][1] = v0;
    s[2][2] = '0;
    return s;
  endfunction

  function automatic logic last_row(input row_kind_t k, input logic [1:0] sel);
    return (k == ROW_RES && !sel[JSEL_POSE] && !sel[JSEL_EXT]) ||
           (k == ROW_POSE_V && !sel[JSEL_EXT]) || (k == ROW_EXT_V);
  endfunction

  function automatic row_kind_t next_row(input row_kind_t k, input logic [1:0] sel);
    row_kind_t n;
    unique case (k)
      ROW_RES:    n = sel[JSEL_POSE] ? ROW_POSE_U : ROW_EXT_U;
      ROW_POSE_U: n = ROW_POSE_V;
      ROW_POSE_V: n = ROW_EXT_U;
      ROW_EXT_U:  n = ROW_EXT_V;
      default:    n = ROW_RES;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/weighted_reprojection_residual_unit.sv -----
// Pipelined weighted reprojection residual and Jacobian row generator.
//
//  channel | direction | beat contents
//  in_     | slave     | tuser: operation; tdata: point/pose values, observation, confidence
//  out_    | master    | tuser: row_kind; tdata: col0..col5; tlast: final row of a point
//  cfg_    | slave     | cfg_index, cfg_data: extrinsic offset, quaternion, Jacobian select
//
// A beat enters every cycle unless the pipeline stalls; each point leaves it as
// 1 to 5 rows, one per cycle as the output accepts, so the output sets the point rate.
// The depth division is 48 quotient bits, four per stage over twelve stages.
// Synchronous active-low reset clears valid bits, pose and configuration registers.
// An output stall holds the pipeline once a point is at its tail; nothing is dropped.
`timescale 1ns / 1ps
module weighted_reprojection_residual_unit #(
  parameter int FOCAL_GAIN = wrr_pkg::FOCAL_GAIN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // value_x, value_y, value_z, value_w, obs_u, obs_v, confidence
  input  logic [wrr_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic [wrr_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // col0, col1, col2, col3, col4, col5
  output logic [wrr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // row_kind
  output logic [wrr_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wrr_pkg::*;

  localparam int GAIN   = 2 * FOCAL_GAIN;
  localparam int GAIN_W = $clog2(GAIN + 1) + 1;
  localparam logic signed [GAIN_W-1:0] GAIN_Q = GAIN_W'(GAIN);

  item_t     st_r [NSTG];
  item_t     st_nxt [1:NSTG-1];
  item_t     in_item;
  item_t     hold_r;
  ctx_t      ctx;
  q_t        pos_r [3];
  q_t        rb_r [3][3];
  q_t        ext_t_r [3];
  q_t        ext_q_r [4];
  logic [1:0] jsel_r;
  p_t        rcq_r [9];
  q_t        rc_r [3][3];
  q_t        nrc_r [3][3];
  logic      hold_vld_r;
  row_kind_t hold_kind_r;
  logic      out_vld_r;
  row_kind_t out_kind_r;
  logic      out_last_r;
  q_t        out_cols_r [6];
  q_t        row_cols [6];
  logic      adv, tail_pt, out_free, emit, hold_last, hold_take;

  function automatic item_t stage_fn(input int k, input item_t i, input ctx_t c);
    item_t              o;
    logic [32:0]        r2;
    logic signed [63:0] t;
    q_t                 num [3];
    logic [31:0]        amag;
    logic [QUO_W-1:0]   qm;
    q_t                 m;
    o = i;
    if (k >= S_DIV0 && k < S_QUOT) begin
      for (int n = 0; n < 3; n++) begin
        for (int s = 0; s < DIV_BITS; s++) begin
          r2 = {o.rem[n], o.quo[n][QUO_W-1]};
          o.quo[n] = {o.quo[n][QUO_W-2:0], 1'b0};
          if (r2 >= {1'b0, o.dmag}) begin
            r2 = r2 - {1'b0, o.dmag};
            o.quo[n][0] = 1'b1;
          end
          o.rem[n] = r2[31:0];
        end
      end
    end
    unique case (k)
      S_SUB: begin
        for (int j = 0; j < 3; j++) o.d[j] = sat32(64'(i.v[j]) - 64'(c.pos[j]));
        o.qp = quat_prod(i.v[0], i.v[1], i.v[2], i.v[3]);
        t = 64'(i.conf) * 64'(GAIN_Q);
        o.wp = t[47:0];
      end
      S_RMAT: begin
        o.w = sat32(64'(i.wp));
        if (i.op == OP_ROT) begin
          o.rb = quat_mat(i.qp);
        end else begin
          o.rb = c.rb;
        end
      end
      S_BPRD: begin
        for (int a = 0; a < 3; a++)
          for (int j = 0; j < 3; j++) o.p[a][j] = mulq(i.rb[j][a], i.d[j]);
      end
      S_BSUM: begin
        for (int a = 0; a < 3; a++)
          o.imu[a] = sat32(64'(i.p[a][0]) + 64'(i.p[a][1]) + 64'(i.p[a][2]));
      end
      S_OFS: begin
        for (int a = 0; a < 3; a++) o.e[a] = sat32(64'(i.imu[a]) - 64'(c.et[a]));
      end
      S_CPRD: begin
        for (int a = 0; a < 3; a++)
          for (int j = 0; j < 3; j++) o.p[a][j] = mulq(c.rc[j][a], i.e[j]);
      end
      S_CSUM: begin
        for (int a = 0; a < 3; a++)
          o.cam[a] = sat32(64'(i.p[a][0]) + 64'(i.p[a][1]) + 64'(i.p[a][2]));
      end
      S_DINIT: begin
        o.dep = sat32(64'(i.cam[2]) + 64'(DEPTH_EPS));
        o.dneg = o.dep[31];
        o.dmag = o.dep[31] ? (~o.dep + 32'd1) : o.dep;
        num[0] = i.cam[0];
        num[1] = i.cam[1];
        num[2] = Q_ONE;
        for (int n = 0; n < 3; n++) begin
          o.an[n] = num[n][31];
          o.az[n] = (num[n] == '0);
          amag = num[n][31] ? (~num[n] + 32'd1) : num[n];
          o.quo[n] = {amag, 16'b0};
          o.rem[n] = '0;
        end
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) o.nrb[a][b] = sat32(-64'(i.rb[b][a]));
        o.sku = skew(i.imu[0], i.imu[1], i.imu[2]);
        o.skc = skew(i.cam[0], i.cam[1], i.cam[2]);
      end
      S_JPRD: begin
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++)
            for (int j = 0; j < 3; j++) begin
              o.jp[0][a][b][j] = mulq(c.rc[j][a], i.nrb[j][b]);
              o.jp[1][a][b][j] = mulq(c.rc[j][a], i.sku[j][b]);
              o.jp[2][a][b][j] = mulq(c.rc[j][a], i.skc[j][b]);
            end
      end
      S_JSUM: begin
        for (int g = 0; g < 3; g++)
          for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
              o.jm[g][a][b] = sat32(64'(i.jp[g][a][b][0]) + 64'(i.jp[g][a][b][1]) +
                                    64'(i.jp[g][a][b][2]));
      end
      S_QUOT: begin
        for (int n = 0; n < 3; n++) begin
          qm = i.quo[n];
          priority if (i.dmag == '0) begin
            o.qt[n] = i.az[n] ? '0 : (i.an[n] ? Q_MIN : Q_MAX);
          end else if (i.an[n] ^ i.dneg) begin
            o.qt[n] = (qm > 48'h0000_8000_0000) ? Q_MIN : q_t'(~qm + 48'd1);
          end else begin
            o.qt[n] = (qm > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(qm);
          end
        end
      end
      S_ERR: begin
        o.rx = sat32(64'(i.qt[0]) - 64'(i.ou));
        o.ry = sat32(64'(i.qt[1]) - 64'(i.ov));
        o.mxi = mulq(i.qt[0], i.qt[2]);
        o.myi = mulq(i.qt[1], i.qt[2]);
        t = 64'(i.qt[2]) * 64'(GAIN_Q);
        o.ig = t[47:0];
      end
      S_WRES: begin
        o.resu_p = mulq(i.w, i.rx);
        o.resv_p = mulq(i.w, i.ry);
        o.red0 = sat32(64'(i.ig));
        o.tx = sat32(-64'(i.mxi));
        o.ty = sat32(-64'(i.myi));
      end
      S_RSAT: begin
        o.resu = sat32(64'(i.resu_p));
        o.resv = sat32(64'(i.resv_p));
        t = 64'(i.tx) * 64'(GAIN_Q);
        o.redx_p = t[47:0];
        t = 64'(i.ty) * 64'(GAIN_Q);
        o.redy_p = t[47:0];
      end
      S_RED: begin
        o.redx = sat32(64'(i.redx_p));
        o.redy = sat32(64'(i.redy_p));
      end
      S_CRP: begin
        o.crp[0] = mulq(i.conf, i.red0);
        o.crp[1] = mulq(i.conf, i.redx);
        o.crp[2] = mulq(i.conf, i.redy);
      end
      S_CR: begin
        o.cr[0][0] = sat32(64'(i.crp[0]));
        o.cr[0][1] = '0;
        o.cr[0][2] = sat32(64'(i.crp[1]));
        o.cr[1][0] = '0;
        o.cr[1][1] = sat32(64'(i.crp[0]));
        o.cr[1][2] = sat32(64'(i.crp[2]));
      end
      S_EPRD: begin
        for (int g = 0; g < 2; g++)
          for (int a = 0; a < 2; a++)
            for (int cc = 0; cc < 6; cc++)
              for (int j = 0; j < 3; j++) begin
                if (cc < 3) begin
                  m = (g == 0) ? i.jm[0][j][cc] : c.nrc[j][cc];
                end else begin
                  m = (g == 0) ? i.jm[1][j][cc-3] : i.jm[2][j][cc-3];
                end
                o.ep[g][a][cc][j] = mulq(i.cr[a][j], m);
              end
      end
      S_ROW: begin
        for (int g = 0; g < 2; g++)
          for (int a = 0; a < 2; a++)
            for (int cc = 0; cc < 6; cc++)
              o.jr[g][a][cc] = sat32(64'(i.ep[g][a][cc][0]) + 64'(i.ep[g][a][cc][1]) +
                                     64'(i.ep[g][a][cc][2]));
      end
      default: ;
    endcase
    return o;
  endfunction

  always_comb begin
    in_item = '{default: '0};
    in_item.vld = in_tvalid;
    in_item.op = in_tuser;
    in_item.v[0] = in_tdata[31:0];
    in_item.v[1] = in_tdata[63:32];
    in_item.v[2] = in_tdata[95:64];
    in_item.v[3] = in_tdata[127:96];
    in_item.ou = in_tdata[159:128];
    in_item.ov = in_tdata[191:160];
    in_item.conf = in_tdata[223:192];
  end

  always_comb begin
    ctx.pos = pos_r;
    ctx.et = ext_t_r;
    ctx.rb = rb_r;
    ctx.rc = rc_r;
    ctx.nrc = nrc_r;
  end

  always_comb begin
    for (int k = 1; k < NSTG; k++) st_nxt[k] = stage_fn(k, st_r[k-1], ctx);
  end

  assign tail_pt   = st_r[NSTG-1].vld && (st_r[NSTG-1].op == OP_POINT);
  assign out_free  = !out_vld_r || out_tready;
  assign emit      = out_free && hold_vld_r;
  assign hold_last = last_row(hold_kind_r, jsel_r);
  assign hold_take = !hold_vld_r || (emit && hold_last);
  assign adv       = !tail_pt || hold_take;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) st_r[k].vld <= 1'b0;
    end else if (adv) begin
      st_r[0] <= in_item;
      for (int k = 1; k < NSTG; k++) st_r[k] <= st_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= '0;
        for (int b = 0; b < 3; b++) rb_r[a][b] <= (a == b) ? Q_ONE : '0;
      end
    end else if (adv) begin
      if (st_r[0].vld && st_r[0].op == OP_POS) begin
        for (int a = 0; a < 3; a++) pos_r[a] <= st_r[0].v[a];
      end
      if (st_r[S_RMAT-1].vld && st_r[S_RMAT-1].op == OP_ROT) begin
        rb_r <= st_nxt[S_RMAT].rb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) ext_t_r[a] <= '0;
      ext_q_r[0] <= '0;
      ext_q_r[1] <= '0;
      ext_q_r[2] <= '0;
      ext_q_r[3] <= Q_ONE;
      jsel_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TX:   ext_t_r[0] <= cfg_data;
        CFG_TY:   ext_t_r[1] <= cfg_data;
        CFG_TZ:   ext_t_r[2] <= cfg_data;
        CFG_QW:   ext_q_r[3] <= cfg_data;
        CFG_QX:   ext_q_r[0] <= cfg_data;
        CFG_QY:   ext_q_r[1] <= cfg_data;
        CFG_QZ:   ext_q_r[2] <= cfg_data;
        default:  jsel_r <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rcq_r <= quat_prod(ext_q_r[0], ext_q_r[1], ext_q_r[2], ext_q_r[3]);
    rc_r <= quat_mat(rcq_r);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) nrc_r[a][b] <= sat32(-64'(rc_r[b][a]));
  end

  always_comb begin
    for (int cc = 0; cc < 6; cc++) row_cols[cc] = '0;
    unique case (hold_kind_r)
      ROW_RES: begin
        row_cols[0] = hold_r.resu;
        row_cols[1] = hold_r.resv;
      end
      ROW_POSE_U: row_cols = hold_r.jr[0][0];
      ROW_POSE_V: row_cols = hold_r.jr[0][1];
      ROW_EXT_U:  row_cols = hold_r.jr[1][0];
      default:    row_cols = hold_r.jr[1][1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      hold_kind_r <= ROW_RES;
    end else if (adv && tail_pt) begin
      hold_vld_r <= 1'b1;
      hold_kind_r <= ROW_RES;
      hold_r <= st_r[NSTG-1];
    end else if (emit && hold_last) begin
      hold_vld_r <= 1'b0;
    end else if (emit) begin
      hold_kind_r <= next_row(hold_kind_r, jsel_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
      out_kind_r <= hold_kind_r;
      out_last_r <= hold_last;
      out_cols_r <= row_cols;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_cols_r[5], out_cols_r[4], out_cols_r[3],
                       out_cols_r[2], out_cols_r[1], out_cols_r[0]};

endmodule
